### hdl/mtcl_pkg.sv
// Shared types, constants and helper functions of the Move/Turn line parser.
`default_nettype none
package mtcl_pkg;

  localparam int unsigned ValueWidthDefault = 32;
  localparam int unsigned OutWidth          = 32;

  typedef enum logic [7:0] {
    PH_KEY_LEAD   = 8'b0000_0001,
    PH_KEY        = 8'b0000_0010,
    PH_KEY_TRAIL  = 8'b0000_0100,
    PH_VAL_LEAD   = 8'b0000_1000,
    PH_VAL_SIGN   = 8'b0001_0000,
    PH_VAL_DIGITS = 8'b0010_0000,
    PH_VAL_TRAIL  = 8'b0100_0000,
    PH_VAL_BAD    = 8'b1000_0000
  } phase_e;

  localparam logic [3:0] KeyNone  = 4'd0;
  localparam logic [3:0] KeyM     = 4'd1;
  localparam logic [3:0] KeyMo    = 4'd2;
  localparam logic [3:0] KeyMov   = 4'd3;
  localparam logic [3:0] KeyMove  = 4'd4;
  localparam logic [3:0] KeyT     = 4'd5;
  localparam logic [3:0] KeyTu    = 4'd6;
  localparam logic [3:0] KeyTur   = 4'd7;
  localparam logic [3:0] KeyTurn  = 4'd8;
  localparam logic [3:0] KeyFail  = 4'd15;

  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChEquals = 8'h3D;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  // closing of a token: which store takes the value
  typedef struct packed {
    logic move_wr;
    logic turn_wr;
  } tok_close_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic [3:0] key_next(input logic [3:0] key, input logic [7:0] c);
    logic [3:0] nxt;
    nxt = KeyFail;
    unique case (key)
      KeyNone: begin
        if (c == "M") nxt = KeyM;
        else if (c == "T") nxt = KeyT;
      end
      KeyM:   if (c == "o") nxt = KeyMo;
      KeyMo:  if (c == "v") nxt = KeyMov;
      KeyMov: if (c == "e") nxt = KeyMove;
      KeyT:   if (c == "u") nxt = KeyTu;
      KeyTu:  if (c == "r") nxt = KeyTur;
      KeyTur: if (c == "n") nxt = KeyTurn;
      default: nxt = KeyFail;
    endcase
    return nxt;
  endfunction

endpackage
`default_nettype wire

### hdl/mtcl_token.sv
// Per-token parse state: key matcher, value phase, sign and digit accumulator.
`default_nettype none
module mtcl_token #(
  parameter int unsigned VALUE_WIDTH = mtcl_pkg::ValueWidthDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   take_i,
  input  wire logic [7:0]             char_code_i,
  input  wire logic                   line_end_i,
  output mtcl_pkg::tok_close_t        close_o,
  output logic [VALUE_WIDTH-1:0]      value_o
);
  import mtcl_pkg::*;

  phase_e                 phase_q, phase_d, phase_t;
  logic [3:0]             key_q, key_d, key_t;
  logic                   neg_q, neg_d, neg_t;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d, acc_t;
  logic [VALUE_WIDTH-1:0] acc_x10;
  logic [VALUE_WIDTH-1:0] digit;
  logic                   semi, closing, has_value;

  assign semi    = (char_code_i == ChSemi);
  assign closing = take_i && (semi || line_end_i);
  assign digit   = VALUE_WIDTH'(char_code_i[3:0]);
  assign acc_x10 = {acc_q[VALUE_WIDTH-4:0], 3'b000} + {acc_q[VALUE_WIDTH-2:0], 1'b0};

  always_comb begin
    phase_t = phase_q;
    key_t   = key_q;
    neg_t   = neg_q;
    acc_t   = acc_q;
    if (!semi) begin
      unique case (phase_q)
        PH_KEY_LEAD: begin
          if (char_code_i == ChEquals) begin
            phase_t = ((key_q == KeyMove) || (key_q == KeyTurn)) ? PH_VAL_LEAD : PH_VAL_BAD;
          end else if (!is_ws(char_code_i)) begin
            key_t   = key_next(key_q, char_code_i);
            phase_t = PH_KEY;
          end
        end
        PH_KEY: begin
          if (char_code_i == ChEquals) begin
            phase_t = ((key_q == KeyMove) || (key_q == KeyTurn)) ? PH_VAL_LEAD : PH_VAL_BAD;
          end else if (is_ws(char_code_i)) begin
            phase_t = PH_KEY_TRAIL;
          end else begin
            key_t = key_next(key_q, char_code_i);
          end
        end
        PH_KEY_TRAIL: begin
          if (char_code_i == ChEquals) begin
            phase_t = ((key_q == KeyMove) || (key_q == KeyTurn)) ? PH_VAL_LEAD : PH_VAL_BAD;
          end else if (!is_ws(char_code_i)) begin
            key_t = KeyFail;
          end
        end
        PH_VAL_LEAD: begin
          if (!is_ws(char_code_i)) begin
            if ((char_code_i == ChPlus) || (char_code_i == ChMinus)) begin
              neg_t   = (char_code_i == ChMinus);
              phase_t = PH_VAL_SIGN;
            end else if (is_digit(char_code_i)) begin
              acc_t   = digit;
              phase_t = PH_VAL_DIGITS;
            end else begin
              phase_t = PH_VAL_BAD;
            end
          end
        end
        PH_VAL_SIGN: begin
          if (is_digit(char_code_i)) begin
            acc_t   = digit;
            phase_t = PH_VAL_DIGITS;
          end else begin
            phase_t = PH_VAL_BAD;
          end
        end
        PH_VAL_DIGITS: begin
          if (is_digit(char_code_i)) begin
            acc_t = acc_x10 + digit;
          end else if (is_ws(char_code_i)) begin
            phase_t = PH_VAL_TRAIL;
          end else begin
            phase_t = PH_VAL_BAD;
          end
        end
        PH_VAL_TRAIL: begin
          if (!is_ws(char_code_i)) phase_t = PH_VAL_BAD;
        end
        default: phase_t = phase_q;
      endcase
    end
  end

  assign has_value        = (phase_t == PH_VAL_DIGITS) || (phase_t == PH_VAL_TRAIL);
  assign close_o.move_wr  = closing && has_value && (key_t == KeyMove);
  assign close_o.turn_wr  = closing && has_value && (key_t == KeyTurn);
  assign value_o          = neg_t ? (VALUE_WIDTH'(0) - acc_t) : acc_t;

  always_comb begin
    phase_d = phase_q;
    key_d   = key_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    if (closing) begin
      phase_d = PH_KEY_LEAD;
      key_d   = KeyNone;
      neg_d   = 1'b0;
      acc_d   = '0;
    end else if (take_i) begin
      phase_d = phase_t;
      key_d   = key_t;
      neg_d   = neg_t;
      acc_d   = acc_t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_KEY_LEAD;
      key_q   <= KeyNone;
      neg_q   <= 1'b0;
      acc_q   <= '0;
    end else begin
      phase_q <= phase_d;
      key_q   <= key_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
    end
  end

endmodule
`default_nettype wire

### hdl/move_turn_command_line_parser.sv
// Top level of the Move/Turn command line parser: value stores and result register.
// Takes one byte per cycle unless a waiting result is stalled (out_ready_i low).
// A new byte is taken in the same cycle a waiting result is transferred.
// The result of a line is shown the cycle after its last byte.
// Reset (asynchronous, active low) clears the token state, both stores and the result.
`default_nettype none
module move_turn_command_line_parser #(
  parameter int unsigned VALUE_WIDTH = mtcl_pkg::ValueWidthDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [7:0]                      char_code_i,
  input  wire logic                            line_end_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [mtcl_pkg::OutWidth-1:0] move_value_o,
  output logic signed [mtcl_pkg::OutWidth-1:0] turn_value_o
);
  import mtcl_pkg::*;

  tok_close_t                    close;
  logic [VALUE_WIDTH-1:0]        value;
  logic                          take, line_done;
  logic [VALUE_WIDTH-1:0]        move_q, move_d, move_new;
  logic [VALUE_WIDTH-1:0]        turn_q, turn_d, turn_new;
  logic                          out_valid_q, out_valid_d;
  logic signed [OutWidth-1:0]    move_out_q, move_out_d;
  logic signed [OutWidth-1:0]    turn_out_q, turn_out_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign line_done  = take && line_end_i;

  mtcl_token #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_token (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .char_code_i(char_code_i),
    .line_end_i (line_end_i),
    .close_o    (close),
    .value_o    (value)
  );

  assign move_new = close.move_wr ? value : move_q;
  assign turn_new = close.turn_wr ? value : turn_q;

  always_comb begin
    move_d      = line_done ? '0 : move_new;
    turn_d      = line_done ? '0 : turn_new;
    out_valid_d = out_valid_q && !out_ready_i;
    move_out_d  = move_out_q;
    turn_out_d  = turn_out_q;
    if (line_done) begin
      out_valid_d = 1'b1;
      move_out_d  = OutWidth'(signed'(move_new));
      turn_out_d  = OutWidth'(signed'(turn_new));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_q      <= '0;
      turn_q      <= '0;
      out_valid_q <= 1'b0;
      move_out_q  <= '0;
      turn_out_q  <= '0;
    end else begin
      move_q      <= move_d;
      turn_q      <= turn_d;
      out_valid_q <= out_valid_d;
      move_out_q  <= move_out_d;
      turn_out_q  <= turn_out_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign move_value_o = move_out_q;
  assign turn_value_o = turn_out_q;

endmodule
`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the Move/Turn command line parser.
`timescale 1ns / 100ps
module tb_top;
  import mtcl_pkg::*;

  localparam int QuietLimit = 2000;

  typedef logic [7:0] line_t[$];

  class move_turn_scoreboard;
    typedef struct packed {
      logic [31:0] move_val;
      logic [31:0] turn_val;
    } line_result_t;

    phase_e       tok_phase;
    logic [3:0]   key_state;
    logic         neg;
    logic [31:0]  acc;
    logic [31:0]  move_st;
    logic [31:0]  turn_st;
    line_result_t line_results_q[$];
    int           errors;

    function new();
      clear_line();
      errors = 0;
    endfunction

    function int pending();
      return line_results_q.size();
    endfunction

    function bit is_blank(logic [7:0] c);
      return (c == ChSpace) || (c >= ChTab && c <= ChCr);
    endfunction

    function bit is_num(logic [7:0] c);
      return c >= ChZero && c <= ChNine;
    endfunction

    function void clear_token();
      tok_phase = PH_KEY_LEAD;
      key_state = KeyNone;
      neg       = 1'b0;
      acc       = '0;
    endfunction

    function void clear_line();
      clear_token();
      move_st = '0;
      turn_st = '0;
    endfunction

    function void close_token();
      logic [31:0] v;
      if (tok_phase == PH_VAL_DIGITS || tok_phase == PH_VAL_TRAIL) begin
        v = neg ? -acc : acc;
        if (key_state == KeyMove) move_st = v;
        else if (key_state == KeyTurn) turn_st = v;
      end
      clear_token();
    endfunction

    function void open_value();
      tok_phase = (key_state == KeyMove || key_state == KeyTurn) ? PH_VAL_LEAD : PH_VAL_BAD;
    endfunction

    function void step_key(logic [7:0] c);
      string mw = "Move";
      string tw = "Turn";
      if (key_state == KeyNone)
        key_state = (c == mw[0]) ? KeyM : (c == tw[0]) ? KeyT : KeyFail;
      else if (key_state >= KeyM && key_state <= KeyMov)
        key_state = (c == mw[int'(key_state)]) ? key_state + 4'd1 : KeyFail;
      else if (key_state >= KeyT && key_state <= KeyTur)
        key_state = (c == tw[int'(key_state - KeyMove)]) ? key_state + 4'd1 : KeyFail;
      else
        key_state = KeyFail;
    endfunction

    // accepted input transfer
    function void take_byte(logic [7:0] c, logic last);
      if (c == ChSemi) begin
        close_token();
      end else begin
        case (tok_phase)
          PH_KEY_LEAD: begin
            if (!is_blank(c)) begin
              if (c == ChEquals) begin
                open_value();
              end else begin
                step_key(c);
                tok_phase = PH_KEY;
              end
            end
          end
          PH_KEY: begin
            if (c == ChEquals) open_value();
            else if (is_blank(c)) tok_phase = PH_KEY_TRAIL;
            else step_key(c);
          end
          PH_KEY_TRAIL: begin
            if (c == ChEquals) open_value();
            else if (!is_blank(c)) key_state = KeyFail;
          end
          PH_VAL_LEAD: begin
            if (!is_blank(c)) begin
              if (c == ChPlus || c == ChMinus) begin
                neg = (c == ChMinus);
                tok_phase = PH_VAL_SIGN;
              end else if (is_num(c)) begin
                acc = 32'(c - ChZero);
                tok_phase = PH_VAL_DIGITS;
              end else begin
                tok_phase = PH_VAL_BAD;
              end
            end
          end
          PH_VAL_SIGN: begin
            if (is_num(c)) begin
              acc = 32'(c - ChZero);
              tok_phase = PH_VAL_DIGITS;
            end else begin
              tok_phase = PH_VAL_BAD;
            end
          end
          PH_VAL_DIGITS: begin
            if (is_num(c)) acc = acc * 32'd10 + 32'(c - ChZero);
            else if (is_blank(c)) tok_phase = PH_VAL_TRAIL;
            else tok_phase = PH_VAL_BAD;
          end
          PH_VAL_TRAIL: begin
            if (!is_blank(c)) tok_phase = PH_VAL_BAD;
          end
          default: ;
        endcase
      end
      if (last) begin
        close_token();
        line_results_q.push_back('{move_st, turn_st});
        clear_line();
      end
    endfunction

    // accepted output transfer
    function void check_result(logic signed [31:0] mv, logic signed [31:0] tn);
      line_result_t want;
      if (line_results_q.size() == 0) begin
        $error("move_value/turn_value: no line result expected, got %0d / %0d", mv, tn);
        errors++;
        return;
      end
      want = line_results_q.pop_front();
      if (mv !== want.move_val) begin
        $error("move_value: expected %0d, got %0d", $signed(want.move_val), mv);
        errors++;
      end
      if (tn !== want.turn_val) begin
        $error("turn_value: expected %0d, got %0d", $signed(want.turn_val), tn);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic [7:0]         char_code_i = '0;
  logic               line_end_i  = 1'b0;
  logic               out_ready_i = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic signed [31:0] move_value_o;
  logic signed [31:0] turn_value_o;

  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet     = 0;

  move_turn_scoreboard sb = new();

  move_turn_command_line_parser dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .line_end_i   (line_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .move_value_o (move_value_o),
    .turn_value_o (turn_value_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  // transfer monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(move_value_o, turn_value_o);
      if (in_valid_i && in_ready_o) sb.take_byte(char_code_i, line_end_i);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic last);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    line_end_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_line(input line_t ln);
    foreach (ln[i]) send_byte(ln[i], i == ln.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic void add_text(ref line_t ln, input string s);
    for (int i = 0; i < s.len(); i++) ln.push_back(s[i]);
  endfunction

  function automatic void add_blanks(ref line_t ln, input int n);
    int k;
    repeat (n) begin
      k = $urandom_range(5);
      ln.push_back(k == 5 ? ChSpace : ChTab + 8'(k));
    end
  endfunction

  function automatic void add_token(ref line_t ln);
    string bad_keys[8] = '{"", "Mov", "Turnn", "move", "M ove", "Tu", "X", "TurnMove"};
    int    sel;
    int    vs;
    int    sgn;
    int    ndig;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 6)) ln.push_back(8'($urandom_range(255)));
      return;
    end
    add_blanks(ln, $urandom_range(2));
    sel = $urandom_range(99);
    if (sel < 40) add_text(ln, "Move");
    else if (sel < 80) add_text(ln, "Turn");
    else add_text(ln, bad_keys[$urandom_range(7)]);
    add_blanks(ln, $urandom_range(2));
    if ($urandom_range(19) != 0) ln.push_back(ChEquals);
    add_blanks(ln, $urandom_range(2));
    vs = $urandom_range(99);
    if (vs >= 4) begin
      sgn = $urandom_range(2);
      if (sgn == 1) ln.push_back(ChPlus);
      else if (sgn == 2) ln.push_back(ChMinus);
      if (vs >= 8 && vs < 12) add_blanks(ln, 1);
      if (vs >= 8) begin
        ndig = ($urandom_range(9) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 14);
        repeat (ndig) ln.push_back(ChZero + 8'($urandom_range(9)));
      end
    end
    add_blanks(ln, $urandom_range(2));
    if ($urandom_range(9) == 0) ln.push_back(8'($urandom_range(255)));
  endfunction

  function automatic line_t make_line();
    line_t ln;
    int    ntok;
    ntok = $urandom_range(4);
    for (int t = 0; t < ntok; t++) begin
      if (t != 0) ln.push_back(ChSemi);
      add_token(ln);
    end
    if ($urandom_range(4) == 0) ln.push_back(ChSemi);
    if (ln.size() == 0) ln.push_back(8'($urandom_range(255)));
    return ln;
  endfunction

  initial begin
    int    idle_tab[4]  = '{0, 82, 0, 35};
    int    stall_tab[4] = '{0, 0, 82, 35};
    int    sent;
    line_t ln;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    ln = {8'hFF};
    send_line(ln);
    ln = {8'h00};
    send_line(ln);
    ln = {};
    add_text(ln, "Move=-9");
    send_line(ln);
    ln = {};
    add_text(ln, "Turn=+3 ;=;x");
    send_line(ln);
    ln = {};
    add_text(ln, "Move=99999999999");
    send_line(ln);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_tab[p];
      stall_pct <= stall_tab[p];
      sent = 0;
      while (sent < 500) begin
        ln = make_line();
        send_line(ln);
        sent += ln.size();
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### move_turn_command_line_parser.f
hdl/mtcl_pkg.sv
hdl/mtcl_token.sv
hdl/move_turn_command_line_parser.sv
verif/tb_top.sv
